>>> src/dcp_pkg.sv
// Shared types, constants and helpers for the distance constraint projection core.
package dcp_pkg;

    localparam int POS_W   = 32;
    localparam int MAG_W   = 33;
    localparam int SUM_W   = 66;
    localparam int ROOT_W  = 35;
    localparam int DIST_W  = 34;
    localparam int NUM_W   = 67;
    localparam int QUOT_W  = 34;
    localparam int STIFF_W = 18;
    localparam int PROD_W  = QUOT_W + STIFF_W;
    localparam int CORR_W  = 37;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int LANES   = 3;

    localparam logic [STIFF_W-1:0] STIFF_RESET = 18'd65536;
    localparam logic [POS_W-1:0]   FLOOR_RESET = 32'hFFCE_0000;
    localparam logic [PROD_W:0]    ROUND_HALF  = 53'd65536;

    typedef enum logic
    {
        REG_STIFFNESS = 1'b0,
        REG_FLOOR     = 1'b1
    } reg_sel_t;

    typedef struct packed
    {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic               first_enabled;
        logic               second_enabled;
        logic               first_movable;
        logic               second_movable;
        logic [30:0]        rest_length;
    } req_t;

    typedef struct packed
    {
        logic signed [31:0] new_first_x;
        logic signed [31:0] new_first_y;
        logic signed [31:0] new_first_z;
        logic signed [31:0] new_second_x;
        logic signed [31:0] new_second_y;
        logic signed [31:0] new_second_z;
        logic               applied;
    } resp_t;

    typedef struct packed
    {
        req_t                         req;
        logic [LANES-1:0][MAG_W-1:0]  mag;
        logic [LANES-1:0]             dneg;
        logic                         both_en;
    } ctx_t;

    typedef struct packed
    {
        logic [DIST_W-1:0] dlen;
        logic [DIST_W-1:0] dmag;
        logic              lneg;
        logic              nz;
    } len_t;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        begin
            if (v > 38'sh0_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (v < -38'sh0_8000_0000)
                r = 32'sh8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

>>> src/dcp_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module dcp_isqrt
    import dcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SUM_W-1:0]  sum,
    input  ctx_t              in_ctx,
    output logic              out_valid,
    output logic [DIST_W-1:0] root,
    output ctx_t              out_ctx
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic [ROOT_W:1]     v;
    logic [REM_W-1:0]    rem_reg [1:ROOT_W];
    logic [ROOT_W-1:0]   rt_reg  [1:ROOT_W];
    logic [RAD_W-1:0]    rad_reg [1:ROOT_W];
    ctx_t                ctx_reg [1:ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_step
            logic              v_in;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] rt_in;
            logic [RAD_W-1:0]  rad_in;
            ctx_t              ctx_in;
            logic [REM_W-1:0]  sh;
            logic [REM_W-1:0]  trial;

            if (k == 0)
            begin : g_head
                assign v_in   = in_valid;
                assign rem_in = '0;
                assign rt_in  = '0;
                assign rad_in = {{(RAD_W-SUM_W){1'b0}}, sum};
                assign ctx_in = in_ctx;
            end
            else
            begin : g_body
                assign v_in   = v[k];
                assign rem_in = rem_reg[k];
                assign rt_in  = rt_reg[k];
                assign rad_in = rad_reg[k];
                assign ctx_in = ctx_reg[k];
            end

            always_comb
            begin
                sh    = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
                trial = {1'b0, rt_in, 2'b01};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v[k+1] <= 1'b0;
                else if (en)
                    v[k+1] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (sh >= trial)
                    begin
                        rem_reg[k+1] <= sh - trial;
                        rt_reg[k+1]  <= {rt_in[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k+1] <= sh;
                        rt_reg[k+1]  <= {rt_in[ROOT_W-2:0], 1'b0};
                    end
                    rad_reg[k+1] <= {rad_in[RAD_W-3:0], 2'b00};
                    ctx_reg[k+1] <= ctx_in;
                end
            end
        end
    endgenerate

    assign out_valid = v[ROOT_W];
    assign root      = rt_reg[ROOT_W][DIST_W-1:0];
    assign out_ctx   = ctx_reg[ROOT_W];

endmodule

>>> src/dcp_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module dcp_div
    import dcp_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]  num,
    input  ctx_t                         in_ctx,
    input  len_t                         in_len,
    output logic                         out_valid,
    output logic [LANES-1:0][QUOT_W-1:0] quot,
    output ctx_t                         out_ctx,
    output len_t                         out_len
);

    localparam int REM_W = DIST_W + 1;

    logic [QUOT_W:1]                 v;
    logic [LANES-1:0][REM_W-1:0]     r_reg [1:QUOT_W];
    logic [LANES-1:0][QUOT_W-1:0]    q_reg [1:QUOT_W];
    logic [LANES-1:0][NUM_W-1:0]     n_reg [1:QUOT_W];
    ctx_t                            ctx_reg [1:QUOT_W];
    len_t                            len_reg [1:QUOT_W];

    genvar k, i;
    generate
        for (k = 0; k < QUOT_W; k++)
        begin : g_step
            localparam int J = QUOT_W - 1 - k;

            logic                         v_in;
            logic [LANES-1:0][REM_W-1:0]  r_in;
            logic [LANES-1:0][QUOT_W-1:0] q_in;
            logic [LANES-1:0][NUM_W-1:0]  n_in;
            ctx_t                         ctx_in;
            len_t                         len_in;

            if (k == 0)
            begin : g_head
                assign v_in   = in_valid;
                assign q_in   = '0;
                assign n_in   = num;
                assign ctx_in = in_ctx;
                assign len_in = in_len;

                always_comb
                begin
                    for (int n = 0; n < LANES; n++)
                        r_in[n] = {{(REM_W-(NUM_W-QUOT_W)){1'b0}}, num[n][NUM_W-1:QUOT_W]};
                end
            end
            else
            begin : g_body
                assign v_in   = v[k];
                assign r_in   = r_reg[k];
                assign q_in   = q_reg[k];
                assign n_in   = n_reg[k];
                assign ctx_in = ctx_reg[k];
                assign len_in = len_reg[k];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v[k+1] <= 1'b0;
                else if (en)
                    v[k+1] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[k+1]   <= n_in;
                    ctx_reg[k+1] <= ctx_in;
                    len_reg[k+1] <= len_in;
                end
            end

            for (i = 0; i < LANES; i++)
            begin : g_lane
                logic [REM_W-1:0] sh;

                assign sh = {r_in[i][REM_W-2:0], n_in[i][J]};

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        if (sh >= {1'b0, len_in.dlen})
                        begin
                            r_reg[k+1][i] <= sh - {1'b0, len_in.dlen};
                            q_reg[k+1][i] <= {q_in[i][QUOT_W-2:0], 1'b1};
                        end
                        else
                        begin
                            r_reg[k+1][i] <= sh;
                            q_reg[k+1][i] <= {q_in[i][QUOT_W-2:0], 1'b0};
                        end
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v[QUOT_W];
    assign quot      = q_reg[QUOT_W];
    assign out_ctx   = ctx_reg[QUOT_W];
    assign out_len   = len_reg[QUOT_W];

endmodule

>>> src/distance_constraint_projection_core.sv
// Top level of the distance constraint projection core.
//
// Projects one particle pair per request onto its rest-length constraint.
// req/req_valid/req_ready carries the two positions, flags and rest length;
// resp/resp_valid/resp_ready returns the corrected positions and applied.
// An APB-style port holds stiffness (offset 0x0) and floor_level (0x4);
// write it only while no request is in flight.
//
// Throughput: one request per cycle while the output is not stalled. The
// pipeline is dominated by the 35-stage square root and the 34-stage
// divider, one result bit per stage.
//
// A single advance enable moves every stage at once; when resp_valid is
// high and resp_ready is low, the whole pipeline holds and req_ready drops.
// Reset clears all stage valid bits and loads stiffness 1.0 and floor -50.0.
module distance_constraint_projection_core
    import dcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  req_t              req,
    input  logic              req_valid,
    output logic              req_ready,
    output resp_t             resp,
    output logic              resp_valid,
    input  logic              resp_ready,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [STIFF_W-1:0] stiff_reg;
    logic [POS_W-1:0]   floor_reg;
    reg_sel_t           sel;
    logic               adv;

    assign sel    = reg_sel_t'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg <= STIFF_RESET;
            floor_reg <= FLOOR_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (sel)
                REG_STIFFNESS: stiff_reg <= pwdata[STIFF_W-1:0];
                REG_FLOOR:     floor_reg <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_STIFFNESS: prdata = {{(DATA_W-STIFF_W){1'b0}}, stiff_reg};
            REG_FLOOR:     prdata = floor_reg;
            default:       prdata = '0;
        endcase
    end

    assign adv       = !resp_valid || resp_ready;
    assign req_ready = adv;

    // stage 1: differences
    logic                         v1_reg;
    ctx_t                         ctx1_reg;
    ctx_t                         ctx_in;
    logic signed [MAG_W-1:0]      d [LANES];

    always_comb
    begin
        d[0] = $signed({req.second_x[31], req.second_x}) - $signed({req.first_x[31], req.first_x});
        d[1] = $signed({req.second_y[31], req.second_y}) - $signed({req.first_y[31], req.first_y});
        d[2] = $signed({req.second_z[31], req.second_z}) - $signed({req.first_z[31], req.first_z});
        ctx_in.req     = req;
        ctx_in.both_en = req.first_enabled && req.second_enabled;
        for (int i = 0; i < LANES; i++)
        begin
            ctx_in.dneg[i] = d[i][MAG_W-1];
            ctx_in.mag[i]  = d[i][MAG_W-1] ? (~d[i] + 1'b1) : d[i];
        end
    end

    // stage 2: squares, stage 3: sum
    logic                          v2_reg, v3_reg;
    ctx_t                          ctx2_reg, ctx3_reg;
    logic [LANES-1:0][2*MAG_W-1:0] sq_reg;
    logic [SUM_W-1:0]              sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= req_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx1_reg <= ctx_in;
            ctx2_reg <= ctx1_reg;
            ctx3_reg <= ctx2_reg;
            for (int i = 0; i < LANES; i++)
                sq_reg[i] <= ctx1_reg.both_en ? ctx1_reg.mag[i] * ctx1_reg.mag[i] : '0;
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    logic              vs;
    logic [DIST_W-1:0] root;
    ctx_t              ctxs;

    dcp_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v3_reg),
        .sum       (sum_reg),
        .in_ctx    (ctx3_reg),
        .out_valid (vs),
        .root      (root),
        .out_ctx   (ctxs)
    );

    // length stage and numerator products
    logic                        v4_reg, v5_reg;
    ctx_t                        ctx4_reg, ctx5_reg;
    len_t                        len4_reg, len5_reg;
    logic [LANES-1:0][NUM_W-1:0] num_reg;
    logic [DIST_W:0]             dd;

    assign dd = {1'b0, root} - {{(DIST_W-30){1'b0}}, ctxs.req.rest_length};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= vs;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx4_reg      <= ctxs;
            len4_reg.dlen <= root;
            len4_reg.lneg <= dd[DIST_W];
            len4_reg.dmag <= dd[DIST_W] ? (~dd[DIST_W-1:0] + 1'b1) : dd[DIST_W-1:0];
            len4_reg.nz   <= root != '0;
            ctx5_reg      <= ctx4_reg;
            len5_reg      <= len4_reg;
            for (int i = 0; i < LANES; i++)
                num_reg[i] <= ctx4_reg.mag[i] * len4_reg.dmag;
        end
    end

    logic                         vd;
    logic [LANES-1:0][QUOT_W-1:0] quot;
    ctx_t                         ctxd;
    len_t                         lend;

    dcp_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v5_reg),
        .num       (num_reg),
        .in_ctx    (ctx5_reg),
        .in_len    (len5_reg),
        .out_valid (vd),
        .quot      (quot),
        .out_ctx   (ctxd),
        .out_len   (lend)
    );

    // scale, round, sign, apply
    logic                                v6_reg, v7_reg;
    ctx_t                                ctx6_reg, ctx7_reg;
    logic                                nz6_reg, nz7_reg;
    logic [LANES-1:0][PROD_W-1:0]        prod_reg;
    logic [LANES-1:0]                    cneg6_reg;
    logic signed [LANES-1:0][CORR_W-1:0] corr_reg;
    logic [PROD_W:0]                     rnd [LANES];
    resp_t                               resp_reg;
    resp_t                               resp_next;
    logic                                resp_valid_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            rnd[i] = {1'b0, prod_reg[i]} + ROUND_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg         <= 1'b0;
            v7_reg         <= 1'b0;
            resp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v6_reg         <= vd;
            v7_reg         <= v6_reg;
            resp_valid_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx6_reg  <= ctxd;
            nz6_reg   <= lend.nz;
            for (int i = 0; i < LANES; i++)
            begin
                prod_reg[i]  <= quot[i] * stiff_reg;
                cneg6_reg[i] <= ctxd.dneg[i] != lend.lneg;
            end
            ctx7_reg <= ctx6_reg;
            nz7_reg  <= nz6_reg;
            for (int i = 0; i < LANES; i++)
            begin
                if (!nz6_reg)
                    corr_reg[i] <= '0;
                else if (cneg6_reg[i])
                    corr_reg[i] <= -$signed({1'b0, rnd[i][PROD_W:17]});
                else
                    corr_reg[i] <= $signed({1'b0, rnd[i][PROD_W:17]});
            end
            resp_reg <= resp_next;
        end
    end

    always_comb
    begin
        logic signed [POS_W-1:0] fl;
        req_t                    r;
        fl = floor_reg;
        r  = ctx7_reg.req;
        resp_next.new_first_x  = r.first_x;
        resp_next.new_first_y  = r.first_y;
        resp_next.new_first_z  = r.first_z;
        resp_next.new_second_x = r.second_x;
        resp_next.new_second_y = r.second_y;
        resp_next.new_second_z = r.second_z;
        resp_next.applied      = ctx7_reg.both_en && nz7_reg;
        if (ctx7_reg.both_en && r.first_movable)
        begin
            resp_next.new_first_x = sat32(38'(r.first_x) + 38'($signed(corr_reg[0])));
            resp_next.new_first_y = sat32(38'(r.first_y) + 38'($signed(corr_reg[1])));
            resp_next.new_first_z = sat32(38'(r.first_z) + 38'($signed(corr_reg[2])));
            if (r.first_y < fl)
                resp_next.new_first_y = fl;
        end
        if (ctx7_reg.both_en && r.second_movable)
        begin
            resp_next.new_second_x = sat32(38'(r.second_x) - 38'($signed(corr_reg[0])));
            resp_next.new_second_y = sat32(38'(r.second_y) - 38'($signed(corr_reg[1])));
            resp_next.new_second_z = sat32(38'(r.second_z) - 38'($signed(corr_reg[2])));
            if (r.second_y < fl)
                resp_next.new_second_y = fl;
        end
    end

    assign resp       = resp_reg;
    assign resp_valid = resp_valid_reg;

    a_zero_corr: assert property (@(posedge clk) disable iff (!rst_n)
        v7_reg && !nz7_reg |-> corr_reg == '0)
        else $error("correction present with zero distance");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid && !resp_ready |-> !req_ready ##1 (resp_valid && $stable(resp_reg)))
        else $error("pipeline moved while output stalled");

    a_stiff_write: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && !paddr[2] |=> stiff_reg == $past(pwdata[STIFF_W-1:0]))
        else $error("stiffness write lost");

    a_applied_en: assert property (@(posedge clk) disable iff (!rst_n)
        adv && v7_reg |=> resp.applied == $past(ctx7_reg.both_en && nz7_reg))
        else $error("applied without both particles enabled");

endmodule

>>> dv/tb_distance_constraint_projection_core.sv
// Testbench for the distance constraint projection core: directed and random pairs checked against a local model.
`timescale 1ns / 100ps

module tb_distance_constraint_projection_core
    import dcp_pkg::*;
;

    logic              clk;
    logic              rst_n;
    req_t              req;
    logic              req_valid;
    logic              req_ready;
    resp_t             resp;
    logic              resp_valid;
    logic              resp_ready;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic [STIFF_W-1:0] stiff_q;
    logic signed [31:0] floor_q;
    resp_t              projected_q[$];
    int                 errors;
    bit                 calm;
    int                 stall_left;

    distance_constraint_projection_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .resp       (resp),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] clip32(longint v);
        logic [31:0] r;
        if (v > 64'sh7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -64'sh8000_0000)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic resp_t project_pair(req_t r);
        longint       p1[3];
        longint       p2[3];
        longint       d[3];
        longint       corr[3];
        logic [127:0] mag;
        logic [127:0] sum;
        logic [127:0] cand;
        logic [127:0] root;
        logic [127:0] dmag;
        logic [127:0] q;
        logic [127:0] c;
        longint       diff;
        bit           dneg;
        bit           both;
        bit           applied;
        resp_t        o;
        p1[0] = longint'(r.first_x);
        p1[1] = longint'(r.first_y);
        p1[2] = longint'(r.first_z);
        p2[0] = longint'(r.second_x);
        p2[1] = longint'(r.second_y);
        p2[2] = longint'(r.second_z);
        sum = '0;
        applied = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = p2[i] - p1[i];
            corr[i] = 0;
            mag = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
            sum = sum + mag * mag;
        end
        both = r.first_enabled && r.second_enabled;
        if (both)
        begin
            root = '0;
            for (int b = 34; b >= 0; b--)
            begin
                cand = root | (128'd1 << b);
                if (cand * cand <= sum)
                    root = cand;
            end
            if (root != 0)
            begin
                applied = 1'b1;
                diff = longint'(root) - longint'(r.rest_length);
                dneg = diff < 0;
                dmag = dneg ? 128'(-diff) : 128'(diff);
                for (int i = 0; i < 3; i++)
                begin
                    mag = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
                    q = (mag * dmag) / root;
                    c = (q * 128'(stiff_q) + 128'd65536) >> 17;
                    corr[i] = ((d[i] < 0) != dneg) ? -longint'(c) : longint'(c);
                end
            end
        end
        o.new_first_x  = p1[0][31:0];
        o.new_first_y  = p1[1][31:0];
        o.new_first_z  = p1[2][31:0];
        o.new_second_x = p2[0][31:0];
        o.new_second_y = p2[1][31:0];
        o.new_second_z = p2[2][31:0];
        if (both && r.first_movable)
        begin
            o.new_first_x = clip32(p1[0] + corr[0]);
            o.new_first_y = clip32(p1[1] + corr[1]);
            o.new_first_z = clip32(p1[2] + corr[2]);
            if (r.first_y < floor_q)
                o.new_first_y = floor_q;
        end
        if (both && r.second_movable)
        begin
            o.new_second_x = clip32(p2[0] - corr[0]);
            o.new_second_y = clip32(p2[1] - corr[1]);
            o.new_second_z = clip32(p2[2] - corr[2]);
            if (r.second_y < floor_q)
                o.new_second_y = floor_q;
        end
        o.applied = applied;
        return o;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    always @(posedge clk)
    begin
        resp_t want;
        if (rst_n && resp_valid && resp_ready)
        begin
            if (projected_q.size() == 0)
                report_mismatch("unexpected response", 32'(resp.applied), 32'h0);
            else
            begin
                want = projected_q.pop_front();
                check_field("new_first_x", resp.new_first_x, want.new_first_x);
                check_field("new_first_y", resp.new_first_y, want.new_first_y);
                check_field("new_first_z", resp.new_first_z, want.new_first_z);
                check_field("new_second_x", resp.new_second_x, want.new_second_x);
                check_field("new_second_y", resp.new_second_y, want.new_second_y);
                check_field("new_second_z", resp.new_second_z, want.new_second_z);
                check_field("applied", 32'(resp.applied), 32'(want.applied));
            end
        end
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            resp_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            resp_ready <= 1'b1;
            stall_left <= gap_len();
        end
    end

    task automatic send_request(req_t r);
        int gap;
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        projected_q = {projected_q, project_pair(r)};
        gap = gap_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (projected_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(reg_sel_t sel, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(4 * int'(sel));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_STIFFNESS)
            stiff_q = value[STIFF_W-1:0];
        else
            floor_q = value;
    endtask

    function automatic req_t make_pair(int x1, int y1, int z1, int x2, int y2, int z2,
                                       bit e1, bit e2, bit m1, bit m2, logic [30:0] rest);
        req_t r;
        r.first_x = x1;
        r.first_y = y1;
        r.first_z = z1;
        r.second_x = x2;
        r.second_y = y2;
        r.second_z = z2;
        r.first_enabled = e1;
        r.second_enabled = e2;
        r.first_movable = m1;
        r.second_movable = m2;
        r.rest_length = rest;
        return r;
    endfunction

    function automatic req_t random_pair();
        req_t r;
        int   span;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             3'($urandom)};
        if ($urandom_range(0, 9) < 7)
        begin
            span = 1 << $urandom_range(4, 22);
            r.second_x = r.first_x + $signed($urandom_range(0, 2 * span)) - span;
            r.second_y = r.first_y + $signed($urandom_range(0, 2 * span)) - span;
            r.second_z = r.first_z + $signed($urandom_range(0, 2 * span)) - span;
            r.rest_length = 31'($urandom_range(0, 2 * span));
            r.first_enabled = $urandom_range(0, 9) != 0;
            r.second_enabled = $urandom_range(0, 9) != 0;
            if ($urandom_range(0, 3) == 0)
            begin
                r.first_y = floor_q + $signed($urandom_range(0, 2 * span)) - span;
                r.second_y = floor_q + $signed($urandom_range(0, 2 * span)) - span;
            end
            if ($urandom_range(0, 19) == 0)
                r.second_x = r.first_x;
            if ($urandom_range(0, 19) == 0)
            begin
                r.second_y = r.first_y;
                r.second_z = r.first_z;
            end
        end
        return r;
    endfunction

    task automatic test_directed();
        send_request(make_pair(0, 0, 0, 32'sd655360, 0, 0, 1, 1, 1, 1, 31'd327680));
        send_request(make_pair(0, 0, 0, 32'sd131072, 0, 0, 1, 1, 1, 1, 31'd524288));
        send_request(make_pair(65536, -65536, 3 << 16, -2 << 16, 5 << 16, 7 << 16,
                               1, 1, 1, 1, 31'd65536));
        send_request(make_pair(0, 0, 0, 32'sd655360, 0, 0, 0, 1, 1, 1, 31'd0));
        send_request(make_pair(0, 0, 0, 32'sd655360, 0, 0, 1, 0, 1, 1, 31'd0));
        send_request(make_pair(0, -60 << 16, 0, 5, -70 << 16, 9, 0, 0, 1, 1, 31'd0));
        send_request(make_pair(5, -60 << 16, 7, 5, -60 << 16, 7, 1, 1, 1, 1, 31'd100));
        send_request(make_pair(5, -60 << 16, 7, 5, -60 << 16, 7, 1, 1, 0, 0, 31'd100));
        send_request(make_pair(0, -60 << 16, 0, 1 << 16, -55 << 16, 0, 1, 1, 0, 1, 31'd0));
        send_request(make_pair(0, -60 << 16, 0, 1 << 16, -55 << 16, 0, 1, 1, 1, 0, 31'd0));
        send_request(make_pair(0, -60 << 16, 0, 1 << 16, -55 << 16, 0, 1, 1, 1, 1, 31'd0));
        send_request(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                               32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                               1, 1, 1, 1, 31'h7FFF_FFFF));
        send_request(make_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                               1, 1, 1, 1, 31'd0));
        send_request(make_pair(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sh7FFF_FFF0, 1, 32'sh8000_0010,
                               1, 1, 1, 1, 31'h7FFF_FFFF));
        send_request(make_pair(0, 0, 0, 1, 0, 0, 1, 1, 1, 1, 31'h7FFF_FFFF));
        send_request(make_pair(-1, -1, -1, 0, 0, 0, 1, 1, 1, 1, 31'd0));
        send_request(make_pair(100, 200, 300, 100, 200, 300, 0, 1, 0, 1, 31'd5));
        drain();
    endtask

    task automatic test_register_extremes();
        logic [31:0] stiff_set[4];
        logic [31:0] floor_set[4];
        stiff_set = '{32'd0, 32'd131072, 32'h3FFFF, 32'd32768};
        floor_set = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, $urandom};
        for (int k = 0; k < 4; k++)
        begin
            write_reg(REG_STIFFNESS, stiff_set[k]);
            write_reg(REG_FLOOR, floor_set[k]);
            calm = k[0];
            for (int n = 0; n < 60; n++)
                send_request(random_pair());
            send_request(make_pair(0, -1000, 0, 3 << 16, 2000, 4 << 16, 1, 1, 1, 1, 31'd65536));
            drain();
        end
        calm = 1'b0;
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_STIFFNESS, 32'($urandom_range(0, 131072)));
            write_reg(REG_FLOOR, $urandom_range(0, 1) ? $urandom : 32'(-($urandom_range(0, 200) << 16)));
            calm = phase == 2;
            for (int n = 0; n < 250; n++)
                send_request(random_pair());
            drain();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req <= '0;
        req_valid <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        errors = 0;
        calm = 1'b0;
        stiff_q = STIFF_RESET;
        floor_q = FLOOR_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_register_extremes();
        test_random_stream();
        if (errors == 0 && projected_q.size() == 0)
            $display("tb_distance_constraint_projection_core passed");
        else
            $display("tb_distance_constraint_projection_core failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_distance_constraint_projection_core failed");
        $finish;
    end

endmodule

>>> sim.f
src/dcp_pkg.sv
src/dcp_isqrt.sv
src/dcp_div.sv
src/distance_constraint_projection_core.sv
dv/tb_distance_constraint_projection_core.sv
